// ===== design/sha256_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef struct packed {
		logic       ld_byte;
		logic       pad;
		logic       len_ld;
		logic       v_init;
		logic       round_en;
		logic [5:0] rnd_idx;
		logic       h_add;
		logic       h_init;
		logic [2:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic pad_extra;
	} sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== design/sha256_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: absorb, 64 rounds, hash update, length block and digest beats.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic s_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic      m_tlast,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_LEN   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] rnd_q;
	logic [2:0] oidx_q;
	logic       fin_q, extra_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_comb begin
		cmd         = '0;
		cmd.rnd_idx = rnd_q;
		cmd.out_idx = oidx_q;
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		m_tlast     = 1'b0;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc) begin
					if (s_tuser == CMD_FINISH) begin
						cmd.pad    = 1'b1;
						cmd.v_init = 1'b1;
						state_d    = ST_ROUND;
					end else begin
						cmd.ld_byte = 1'b1;
						if (sts.fill_last) begin
							cmd.v_init = 1'b1;
							state_d    = ST_ROUND;
						end
					end
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == 6'd63)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.h_add = 1'b1;
				priority if (extra_q)
					state_d = ST_LEN;
				else if (fin_q)
					state_d = ST_OUT;
				else
					state_d = ST_IDLE;
			end
			ST_LEN: begin
				cmd.len_ld = 1'b1;
				cmd.v_init = 1'b1;
				state_d    = ST_ROUND;
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				m_tlast  = (oidx_q == 3'd7);
				if (m_tready && oidx_q == 3'd7) begin
					cmd.h_init = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			oidx_q  <= '0;
			fin_q   <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND)
				rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_IDLE && in_acc && s_tuser == CMD_FINISH) begin
				fin_q   <= 1'b1;
				extra_q <= sts.pad_extra;
			end
			if (state_q == ST_ADD)
				extra_q <= 1'b0;
			if (out_acc) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7)
					fin_q <= 1'b0;
			end
		end
	end

	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> state_q == ST_ADD)
		else $error("round sequence did not end in hash update");
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && oidx_q == 3'd7) |=> (state_q == ST_IDLE && !fin_q))
		else $error("digest end did not return to idle");
	a_extra_fin: assert property (@(posedge clk) disable iff (!arst_n)
		extra_q |-> fin_q)
		else $error("extra length block without finish");

endmodule
`default_nettype wire

// ===== design/sha256_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_dp
// Block buffer and message schedule window, round unit and hash state.
// ----------------------------------------------------------------------------
module sha256_dp import sha256_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  data_byte,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	output logic [31:0]      digest_word
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [63:0] bits;
	logic [31:0] w_new, t1, t2, e, a;

	assign bits = {len_q, 3'b000};
	assign sts.fill_last = (fill_q == 6'd63);
	assign sts.pad_extra = (fill_q >= 6'd56);
	assign digest_word = h_q[cmd.out_idx];

	assign w_new = w_q[0] + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
		+ w_q[9] + (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));

	assign e  = v_q[4];
	assign a  = v_q[0];
	assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + K_TAB[cmd.rnd_idx] + w_q[0];
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		priority if (cmd.ld_byte) begin
			for (int j = 0; j < 16; j++)
				for (int k = 0; k < 4; k++)
					if (6'(4 * j + k) == fill_q)
						w_q[j][31 - 8 * k -: 8] <= data_byte;
		end else if (cmd.pad) begin
			for (int j = 0; j < 16; j++)
				for (int k = 0; k < 4; k++)
					if (6'(4 * j + k) == fill_q)
						w_q[j][31 - 8 * k -: 8] <= PAD_BYTE;
					else if (6'(4 * j + k) > fill_q && (sts.pad_extra || j < 14))
						w_q[j][31 - 8 * k -: 8] <= 8'h00;
			if (!sts.pad_extra) begin
				w_q[14] <= bits[63:32];
				w_q[15] <= bits[31:0];
			end
		end else if (cmd.len_ld) begin
			for (int j = 0; j < 14; j++)
				w_q[j] <= '0;
			w_q[14] <= bits[63:32];
			w_q[15] <= bits[31:0];
		end else if (cmd.round_en) begin
			for (int j = 0; j < 15; j++)
				w_q[j] <= w_q[j + 1];
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.v_init) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= e;
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= a;
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				h_q[i] <= H_INIT[i];
			fill_q <= '0;
			len_q  <= '0;
		end else begin
			priority if (cmd.h_init) begin
				for (int i = 0; i < 8; i++)
					h_q[i] <= H_INIT[i];
				fill_q <= '0;
				len_q  <= '0;
			end else if (cmd.h_add) begin
				for (int i = 0; i < 8; i++)
					h_q[i] <= h_q[i] + v_q[i];
			end else if (cmd.ld_byte) begin
				fill_q <= fill_q + 6'd1;
				len_q  <= len_q + 61'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/sha256_stream_hasher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// Streaming SHA-256: absorb bytes, finish with padding, emit eight digest beats.
// ----------------------------------------------------------------------------
// Absorb beat: the 64th byte of a block also starts 64 rounds through one
// shared round unit, then the hash update; no byte is taken meanwhile.
// Finish beat: pads and hashes the last block, plus a length block when 56
// or more bytes are buffered, then eight digest beats at up to one per cycle.
// Reset: asynchronous; restores the initial hash and clears fill and length.
module sha256_stream_hasher_unit import sha256_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic        s_tuser,  // [0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // [31:0] digest_word, [34:32] word_index
	output logic             m_tlast
);

	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] digest_word;

	sha256_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	sha256_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.digest_word (digest_word)
	);

	assign m_tdata = {5'b00000, cmd.out_idx, digest_word};

endmodule
`default_nettype wire
